/* rtl/gip_pkg.sv */
// Shared types, codes and pass tables for the GIF interlace pixel placer.
`default_nettype none
package gip_pkg;

  // Input opcodes
  localparam logic [1:0] OP_PIXEL   = 2'd0;
  localparam logic [1:0] OP_PALETTE = 2'd1;
  localparam logic [1:0] OP_FRAME   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERLACED  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSPARENT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE        = 3'd4;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Output modes; the unused code behaves as RGBA
  localparam logic [1:0] MODE_INDEXED = 2'd0;
  localparam logic [1:0] MODE_ALPHA   = 2'd1;
  localparam logic [1:0] MODE_RGBA    = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [8:0] NO_TRANSPARENT = 9'h1FF;
  localparam int unsigned COLOR_BITS = 24;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] color_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } gip_in_t;

  typedef struct packed {
    logic [31:0] pixel_number;
    logic [7:0]  out_index;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        frame_done;
    logic [7:0]  highest_index;
  } gip_out_t;

  // Per-pixel attributes passed from the placer to the output stage
  typedef struct packed {
    logic [7:0] index;
    logic [7:0] alpha;
    logic       color_en;
    logic       frame_done;
    logic [7:0] highest;
  } gip_ctl_t;

  // First row of each interlace pass
  function automatic logic [3:0] pass_start(input logic [1:0] pass);
    logic [3:0] r;
    unique case (pass)
      2'd0: r = 4'd0;
      2'd1: r = 4'd4;
      2'd2: r = 4'd2;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  // Row step of each interlace pass
  function automatic logic [3:0] pass_step(input logic [1:0] pass);
    logic [3:0] r;
    unique case (pass)
      2'd0: r = 4'd8;
      2'd1: r = 4'd8;
      2'd2: r = 4'd4;
      default: r = 4'd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/gip_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gip_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/gip_placer.sv */
// Frame position tracking: column, row, interlace pass and highest index.
`default_nettype none
module gip_placer import gip_pkg::*; #(
  parameter int DIM_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gip_in_t             in_data,
  input  wire logic                in_range,
  input  wire logic [DIM_BITS-1:0] image_width,
  input  wire logic [DIM_BITS-1:0] image_height,
  input  wire logic                interlaced,
  input  wire logic [8:0]          transparent_index,
  input  wire logic [1:0]          output_mode,
  output logic                     pix_valid,
  input  wire logic                pix_ready,
  output logic      [DIM_BITS-1:0] pix_row,
  output logic      [DIM_BITS-1:0] pix_column,
  output logic      [DIM_BITS-1:0] pix_width,
  output gip_ctl_t                 pix_ctl
);

  logic [DIM_BITS-1:0] column, column_next;
  logic [DIM_BITS-1:0] row, row_next;
  logic [1:0]          pass_number, pass_next;
  logic                finished, finished_next;
  logic [7:0]          highest_seen, highest_next;

  logic                accept;
  logic                emit;
  logic                alpha_mode;
  logic                is_trans;
  logic [DIM_BITS:0]   col_inc;
  logic [DIM_BITS:0]   row_lin;
  logic [DIM_BITS:0]   row_scan;
  logic [1:0]          pass_scan;
  logic                scan_found;
  logic                scan_fin;

  assign in_ready = !pix_valid || pix_ready;
  assign accept   = in_valid && in_ready;

  assign alpha_mode = output_mode != MODE_INDEXED;
  assign is_trans   = !transparent_index[8] && (transparent_index[7:0] == in_data.color_index);
  assign col_inc    = {1'b0, column} + (DIM_BITS+1)'(1);
  assign row_lin    = {1'b0, row} + (DIM_BITS+1)'(1);

  // Interlaced next row: step within the pass, then skip passes with no rows
  always_comb begin
    row_scan   = {1'b0, row} + (DIM_BITS+1)'(pass_step(pass_number));
    pass_scan  = pass_number;
    scan_found = 1'b0;
    scan_fin   = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!scan_found && !scan_fin) begin
        if (row_scan < {1'b0, image_height}) begin
          scan_found = 1'b1;
        end else if (pass_scan == 2'd3) begin
          scan_fin = 1'b1;
        end else begin
          pass_scan = pass_scan + 2'd1;
          row_scan  = (DIM_BITS+1)'(pass_start(pass_scan));
        end
      end
    end
  end

  // Next state for one accepted transfer
  always_comb begin
    column_next   = column;
    row_next      = row;
    pass_next     = pass_number;
    finished_next = finished;
    highest_next  = highest_seen;
    emit          = 1'b0;
    if (accept) begin
      unique case (in_data.opcode)
        OP_FRAME: begin
          column_next   = '0;
          row_next      = '0;
          pass_next     = 2'd0;
          finished_next = 1'b0;
        end
        OP_PIXEL: begin
          if (!finished) begin
            if (image_width == '0 || image_height == '0 || row >= image_height) begin
              finished_next = 1'b1;
            end else begin
              emit = 1'b1;
              if (!(alpha_mode && is_trans) && in_data.color_index > highest_seen) begin
                highest_next = in_data.color_index;
              end
              if (col_inc >= {1'b0, image_width}) begin
                column_next = '0;
                if (!interlaced) begin
                  if (row_lin >= {1'b0, image_height}) begin
                    finished_next = 1'b1;
                  end else begin
                    row_next = row_lin[DIM_BITS-1:0];
                  end
                end else if (scan_fin) begin
                  finished_next = 1'b1;
                end else begin
                  row_next  = row_scan[DIM_BITS-1:0];
                  pass_next = pass_scan;
                end
              end else begin
                column_next = col_inc[DIM_BITS-1:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row          <= '0;
      pass_number  <= 2'd0;
      finished     <= 1'b0;
      highest_seen <= 8'd0;
    end else begin
      column       <= column_next;
      row          <= row_next;
      pass_number  <= pass_next;
      finished     <= finished_next;
      highest_seen <= highest_next;
    end
  end

  // Pixel stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (in_ready) begin
      pix_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_row            <= row;
      pix_column         <= column;
      pix_width          <= image_width;
      pix_ctl.index      <= in_data.color_index;
      pix_ctl.alpha      <= (alpha_mode && is_trans) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      pix_ctl.color_en   <= (output_mode >= MODE_RGBA) && in_range;
      pix_ctl.frame_done <= finished_next;
      pix_ctl.highest    <= highest_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/gip_format.sv */
// Output stage: pixel number multiply-add, palette color select, result register.
`default_nettype none
module gip_format import gip_pkg::*; #(
  parameter int DIM_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pix_valid,
  output logic                       pix_ready,
  input  wire logic [DIM_BITS-1:0]   pix_row,
  input  wire logic [DIM_BITS-1:0]   pix_column,
  input  wire logic [DIM_BITS-1:0]   pix_width,
  input  wire gip_ctl_t              pix_ctl,
  input  wire logic [COLOR_BITS-1:0] color,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output gip_out_t                   out_data
);

  logic [2*DIM_BITS-1:0]   product;
  logic [31:0]             pixel_number;
  logic [COLOR_BITS-1:0]   color_sel;

  assign pix_ready = !out_valid || out_ready;

  // row * width + column
  assign product      = pix_row * pix_width;
  assign pixel_number = 32'(product) + 32'(pix_column);
  assign color_sel    = pix_ctl.color_en ? color : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_ready) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      out_data.pixel_number  <= pixel_number;
      out_data.out_index     <= pix_ctl.index;
      out_data.red_out       <= color_sel[23:16];
      out_data.green_out     <= color_sel[15:8];
      out_data.blue_out      <= color_sel[7:0];
      out_data.alpha_out     <= pix_ctl.alpha;
      out_data.frame_done    <= pix_ctl.frame_done;
      out_data.highest_index <= pix_ctl.highest;
    end
  end

endmodule
`default_nettype wire

/* rtl/gif_interlace_pixel_placer_unit.sv */
// An accepted pixel is held in the pixel stage register, then passes into the output register.
// Throughput: one item per cycle; input stalls only when pixel and output registers are full and out_ready is low.
// The palette memory read is registered in the RAM; the row*width multiply is registered in the output register.
// Reset: clears position, pass, frame-finished flag and highest index, and returns the
// configuration registers to their defaults; the palette is undefined until written.
`default_nettype none
module gif_interlace_pixel_placer_unit import gip_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int DIM_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire gip_in_t                  in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output gip_out_t                      out_data
);

  localparam int PAL_ADDR_BITS = $clog2(PALETTE_ENTRIES);

  logic [DIM_BITS-1:0]   image_width;
  logic [DIM_BITS-1:0]   image_height;
  logic                  interlaced;
  logic [8:0]            transparent_index;
  logic [1:0]            output_mode;

  logic                  accept;
  logic                  in_range;
  logic                  pal_we;
  logic                  pal_re;
  logic [COLOR_BITS-1:0] pal_rdata;

  logic                  pix_valid;
  logic                  pix_ready;
  logic [DIM_BITS-1:0]   pix_row;
  logic [DIM_BITS-1:0]   pix_column;
  logic [DIM_BITS-1:0]   pix_width;
  gip_ctl_t              pix_ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= DIM_BITS'(1);
      image_height      <= DIM_BITS'(1);
      interlaced        <= 1'b0;
      transparent_index <= NO_TRANSPARENT;
      output_mode       <= MODE_INDEXED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:       image_width       <= cfg_data[DIM_BITS-1:0];
        CFG_HEIGHT:      image_height      <= cfg_data[DIM_BITS-1:0];
        CFG_INTERLACED:  interlaced        <= cfg_data[0];
        CFG_TRANSPARENT: transparent_index <= cfg_data[8:0];
        CFG_MODE:        output_mode       <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Palette port control
  assign accept   = in_valid && in_ready;
  assign in_range = 9'(in_data.color_index) < 9'(PALETTE_ENTRIES);
  assign pal_we   = accept && (in_data.opcode == OP_PALETTE) && in_range;
  assign pal_re   = accept && (in_data.opcode == OP_PIXEL);

  gip_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_data.color_index[PAL_ADDR_BITS-1:0]),
    .wdata ({in_data.red_in, in_data.green_in, in_data.blue_in}),
    .re    (pal_re),
    .raddr (in_data.color_index[PAL_ADDR_BITS-1:0]),
    .rdata (pal_rdata)
  );

  gip_placer #(
    .DIM_BITS (DIM_BITS)
  ) u_placer (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .in_range          (in_range),
    .image_width       (image_width),
    .image_height      (image_height),
    .interlaced        (interlaced),
    .transparent_index (transparent_index),
    .output_mode       (output_mode),
    .pix_valid         (pix_valid),
    .pix_ready         (pix_ready),
    .pix_row           (pix_row),
    .pix_column        (pix_column),
    .pix_width         (pix_width),
    .pix_ctl           (pix_ctl)
  );

  gip_format #(
    .DIM_BITS (DIM_BITS)
  ) u_format (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_row    (pix_row),
    .pix_column (pix_column),
    .pix_width  (pix_width),
    .pix_ctl    (pix_ctl),
    .color      (pal_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
